@@ design/bua_pkg.sv @@
// Shared constants, codes, types and helpers for the batched unique ID allocator.
`default_nettype none
package bua_pkg;

  localparam int ID_W      = 63;
  localparam int FULL_W    = ID_W + 1;
  localparam int BS_W      = 32;
  localparam int RANK_W    = 10;
  localparam int NR_W      = 11;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int OFS_W     = 45;
  localparam int MAX_RANKS = 1024;

  localparam logic [OP_W-1:0] OP_BEGIN_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_SCAN_ID     = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH_INIT = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_ID      = 3'd3;
  localparam logic [OP_W-1:0] OP_REFILL      = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_NEXT   = 3'd3;
  localparam logic [ST_W-1:0] ST_DISABLED  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_INDEX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RANKS  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [FULL_W-1:0] id_value;
    logic [OFS_W-1:0]  fin_init_ofs;
    logic [OFS_W-1:0]  fin_cur_lim_ofs;
    logic [OFS_W-1:0]  fin_sp_lim_ofs;
    logic [OFS_W-1:0]  fin_adv_ofs;
    logic [OFS_W-1:0]  ref_start_ofs;
    logic [OFS_W-1:0]  ref_lim_ofs;
    logic [OFS_W-1:0]  ref_adv_ofs;
  } prep_t;

  typedef struct packed {
    logic [ID_W-1:0] new_id;
    logic [ST_W-1:0] status;
    logic            next_batch_empty;
  } result_t;

  function automatic logic [NR_W-1:0] clamp_ranks(input logic [NR_W-1:0] v);
    clamp_ranks = (v > NR_W'(MAX_RANKS)) ? NR_W'(MAX_RANKS) : v;
  endfunction

endpackage
`default_nettype wire

@@ design/bua_if.sv @@
// Valid/ready channel interfaces for allocator requests and responses.
`default_nettype none
interface bua_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [63:0] id_value;
  logic [9:0]         lower_requests;
  logic [10:0]        total_requests;

  modport source (output valid, opcode, id_value, lower_requests, total_requests,
                  input ready);
  modport sink (input valid, opcode, id_value, lower_requests, total_requests,
                output ready);
endinterface

interface bua_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] new_id;
  logic [2:0]  status;
  logic        next_batch_empty;

  modport source (output valid, new_id, status, next_batch_empty, input ready);
  modport sink (input valid, new_id, status, next_batch_empty, output ready);
endinterface
`default_nettype wire

@@ design/batched_unique_id_allocator.sv @@
// Top level of the batched unique ID allocator: configuration and stage wiring.
//
//   channel  direction  transaction
//   req      in         opcode, id_value, lower_requests, total_requests
//   rsp      out        new_id, status, next_batch_empty
//   cfg      in         cfg_wr_en, cfg_index, cfg_data (write only)
//
// One request per cycle while the response side is not stalled; a request is registered
// in the input stage and its response in the execute stage, where it holds until taken.
// Offset products are formed in the input stage, the ID state updates in the execute stage.
// Reset is synchronous: state clears to zero, configuration returns to its defaults.
// A stalled response holds in its register while one more request waits in the input stage.
`default_nettype none
module batched_unique_id_allocator
  import bua_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  bua_in_if.sink                    req,
  bua_out_if.source                 rsp
);

  logic              enabled;
  logic [BS_W-1:0]   block_len;
  logic [RANK_W-1:0] rank_index;
  logic [NR_W-1:0]   num_ranks;

  logic    prep_valid;
  logic    prep_ready;
  prep_t   prep;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b1;
      block_len  <= BS_W'(1);
      rank_index <= '0;
      num_ranks  <= NR_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENABLED:    enabled    <= cfg_data[0];
        CFG_BLOCK_LEN:  block_len  <= cfg_data[BS_W-1:0];
        CFG_RANK_INDEX: rank_index <= cfg_data[RANK_W-1:0];
        CFG_NUM_RANKS:  num_ranks  <= cfg_data[NR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bua_prep u_prep (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .opcode         (req.opcode),
    .id_value       (req.id_value),
    .lower_requests (req.lower_requests),
    .total_requests (req.total_requests),
    .block_len      (block_len),
    .rank_index     (rank_index),
    .num_ranks      (num_ranks),
    .prep_valid     (prep_valid),
    .prep_ready     (prep_ready),
    .prep           (prep)
  );

  bua_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .enabled    (enabled),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep       (prep),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .result     (result)
  );

  assign rsp.new_id           = result.new_id;
  assign rsp.status           = result.status;
  assign rsp.next_batch_empty = result.next_batch_empty;

endmodule
`default_nettype wire

@@ design/bua_prep.sv @@
// Input stage: register the request and the batch offset products.
`default_nettype none
module bua_prep
  import bua_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [OP_W-1:0]    opcode,
  input  wire logic [FULL_W-1:0]  id_value,
  input  wire logic [RANK_W-1:0]  lower_requests,
  input  wire logic [NR_W-1:0]    total_requests,
  input  wire logic [BS_W-1:0]    block_len,
  input  wire logic [RANK_W-1:0]  rank_index,
  input  wire logic [NR_W-1:0]    num_ranks,
  output      logic               prep_valid,
  input  wire logic               prep_ready,
  output      prep_t              prep
);

  localparam int RB_W = RANK_W + BS_W;
  localparam int NB_W = NR_W + BS_W;

  logic [RB_W-1:0] ri_bs;
  logic [NB_W-1:0] nr_bs;
  logic [RB_W-1:0] lo_bs;
  logic [NB_W-1:0] tot_bs;
  prep_t           prep_next;

  assign ri_bs  = RB_W'(rank_index) * RB_W'(block_len);
  assign nr_bs  = NB_W'(clamp_ranks(num_ranks)) * NB_W'(block_len);
  assign lo_bs  = RB_W'(lower_requests) * RB_W'(block_len);
  assign tot_bs = NB_W'(clamp_ranks(total_requests)) * NB_W'(block_len);

  always_comb begin
    prep_next.opcode          = opcode;
    prep_next.id_value        = id_value;
    prep_next.fin_init_ofs    = OFS_W'({ri_bs, 1'b0}) + OFS_W'(1);
    prep_next.fin_cur_lim_ofs = OFS_W'({ri_bs, 1'b0}) + OFS_W'(block_len) + OFS_W'(1);
    prep_next.fin_sp_lim_ofs  = OFS_W'({ri_bs, 1'b0}) + OFS_W'({block_len, 1'b1});
    prep_next.fin_adv_ofs     = OFS_W'({nr_bs, 1'b0}) + OFS_W'(1);
    prep_next.ref_start_ofs   = OFS_W'(lo_bs);
    prep_next.ref_lim_ofs     = OFS_W'(lo_bs) + OFS_W'(block_len);
    prep_next.ref_adv_ofs     = OFS_W'(tot_bs);
  end

  assign in_ready = !prep_valid || prep_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (in_ready) begin
      prep_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prep <= prep_next;
    end
  end

endmodule
`default_nettype wire

@@ design/bua_exec.sv @@
// Execute stage: allocator state, opcode handling and the result register.
`default_nettype none
module bua_exec
  import bua_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enabled,
  input  wire logic prep_valid,
  output      logic prep_ready,
  input  wire prep_t prep,
  output      logic rsp_valid,
  input  wire logic rsp_ready,
  output      result_t result
);

  logic [ID_W-1:0] global_cursor, global_cursor_next;
  logic [ID_W-1:0] current_next, current_next_next;
  logic [ID_W-1:0] current_limit, current_limit_next;
  logic [ID_W-1:0] spare_start, spare_start_next;
  logic [ID_W-1:0] spare_limit, spare_limit_next;
  result_t         result_next;

  logic [FULL_W-1:0] cur64;
  logic [FULL_W-1:0] fin_init, fin_cur_lim, fin_sp_lim, fin_adv;
  logic              fin_ovf;
  logic [FULL_W-1:0] get_inc;
  logic [FULL_W-1:0] ref_start, ref_lim, ref_adv;
  logic              ref_need, ref_ovf;
  logic              fire;

  assign prep_ready = !rsp_valid || rsp_ready;
  assign fire       = prep_valid && prep_ready;

  assign cur64       = {1'b0, global_cursor};
  assign fin_init    = cur64 + FULL_W'(prep.fin_init_ofs);
  assign fin_cur_lim = cur64 + FULL_W'(prep.fin_cur_lim_ofs);
  assign fin_sp_lim  = cur64 + FULL_W'(prep.fin_sp_lim_ofs);
  assign fin_adv     = cur64 + FULL_W'(prep.fin_adv_ofs);
  assign fin_ovf     = (&global_cursor) || fin_init[ID_W] || fin_cur_lim[ID_W] ||
                       fin_sp_lim[ID_W] || fin_adv[ID_W];

  assign get_inc = {1'b0, current_next} + FULL_W'(1);

  assign ref_need  = (spare_start == '0);
  assign ref_start = cur64 + FULL_W'(prep.ref_start_ofs);
  assign ref_lim   = cur64 + FULL_W'(prep.ref_lim_ofs);
  assign ref_adv   = cur64 + FULL_W'(prep.ref_adv_ofs);
  assign ref_ovf   = (ref_need && ref_lim[ID_W]) || ref_adv[ID_W];

  always_comb begin
    global_cursor_next = global_cursor;
    current_next_next  = current_next;
    current_limit_next = current_limit;
    spare_start_next   = spare_start;
    spare_limit_next   = spare_limit;
    result_next.new_id = '0;
    result_next.status = ST_OK;
    if (!enabled && prep.opcode <= OP_REFILL) begin
      result_next.status = ST_DISABLED;
    end else begin
      case (prep.opcode)
        OP_BEGIN_INIT: begin
          global_cursor_next = '0;
        end
        OP_SCAN_ID: begin
          if (!prep.id_value[ID_W] && prep.id_value[ID_W-1:0] > global_cursor) begin
            global_cursor_next = prep.id_value[ID_W-1:0];
          end
        end
        OP_FINISH_INIT: begin
          if (fin_ovf) begin
            result_next.status = ST_OVERFLOW;
          end else begin
            current_next_next  = fin_init[ID_W-1:0];
            current_limit_next = fin_cur_lim[ID_W-1:0];
            spare_start_next   = fin_cur_lim[ID_W-1:0];
            spare_limit_next   = fin_sp_lim[ID_W-1:0];
            global_cursor_next = fin_adv[ID_W-1:0];
          end
        end
        OP_GET_ID: begin
          if (get_inc > {1'b0, current_limit}) begin
            result_next.status = ST_EXHAUSTED;
          end else if (get_inc == {1'b0, current_limit}) begin
            if (spare_start == '0) begin
              result_next.status = ST_NO_NEXT;
            end else begin
              result_next.new_id = current_next;
              current_next_next  = spare_start;
              current_limit_next = spare_limit;
              spare_start_next   = '0;
              spare_limit_next   = '0;
            end
          end else begin
            result_next.new_id = current_next;
            current_next_next  = get_inc[ID_W-1:0];
          end
        end
        OP_REFILL: begin
          if (ref_ovf) begin
            result_next.status = ST_OVERFLOW;
          end else begin
            if (ref_need) begin
              spare_start_next = ref_start[ID_W-1:0];
              spare_limit_next = ref_lim[ID_W-1:0];
            end
            global_cursor_next = ref_adv[ID_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    result_next.next_batch_empty = (spare_start_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      global_cursor <= '0;
      current_next  <= '0;
      current_limit <= '0;
      spare_start   <= '0;
      spare_limit   <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (fire) begin
        global_cursor <= global_cursor_next;
        current_next  <= current_next_next;
        current_limit <= current_limit_next;
        spare_start   <= spare_start_next;
        spare_limit   <= spare_limit_next;
      end
      if (prep_ready) begin
        rsp_valid <= prep_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ bench/alloc_checker.sv @@
// Transaction monitor that predicts and checks every allocator response.
module alloc_checker
  import bua_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bua_in_if                    req,
  bua_out_if                   rsp,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [64:0] ID_LIMIT = (65'd1 << ID_W) - 65'd1;

  logic              cfg_en;
  logic [BS_W-1:0]   cfg_bs;
  logic [RANK_W-1:0] cfg_rank;
  logic [NR_W-1:0]   cfg_nr;

  logic [ID_W-1:0] cursor;
  logic [ID_W-1:0] cur_next;
  logic [ID_W-1:0] cur_limit;
  logic [ID_W-1:0] spare_start;
  logic [ID_W-1:0] spare_limit;

  result_t expected_rsp_q[$];
  result_t predicted;
  result_t oldest;
  int      fail_cnt;

  task automatic allocate(input logic [OP_W-1:0] op, input logic [63:0] idv,
                          input logic [RANK_W-1:0] lower, input logic [NR_W-1:0] total,
                          output result_t res);
    logic [64:0]     base;
    logic [64:0]     init;
    logic [64:0]     lim_a;
    logic [64:0]     lim_b;
    logic [64:0]     adv;
    logic [64:0]     nxt;
    logic [NR_W-1:0] ranks;
    logic            need;
    res = '0;
    res.status = ST_OK;
    if (op <= OP_REFILL && !cfg_en) begin
      res.status = ST_DISABLED;
    end else begin
      case (op)
        OP_BEGIN_INIT: begin
          cursor = '0;
        end
        OP_SCAN_ID: begin
          if (!idv[63] && idv[ID_W-1:0] > cursor) cursor = idv[ID_W-1:0];
        end
        OP_FINISH_INIT: begin
          ranks = (cfg_nr > NR_W'(MAX_RANKS)) ? NR_W'(MAX_RANKS) : cfg_nr;
          base  = 65'(cursor) + 65'd1;
          init  = base + 65'd2 * 65'(cfg_rank) * 65'(cfg_bs);
          lim_a = init + 65'(cfg_bs);
          lim_b = lim_a + 65'(cfg_bs);
          adv   = base + 65'd2 * 65'(cfg_bs) * 65'(ranks);
          if (65'(cursor) >= ID_LIMIT || lim_b > ID_LIMIT || adv > ID_LIMIT) begin
            res.status = ST_OVERFLOW;
          end else begin
            cur_next    = init[ID_W-1:0];
            cur_limit   = lim_a[ID_W-1:0];
            spare_start = lim_a[ID_W-1:0];
            spare_limit = lim_b[ID_W-1:0];
            cursor      = adv[ID_W-1:0];
          end
        end
        OP_GET_ID: begin
          nxt = 65'(cur_next) + 65'd1;
          if (nxt > 65'(cur_limit)) begin
            res.status = ST_EXHAUSTED;
          end else if (nxt == 65'(cur_limit)) begin
            if (spare_start == '0) begin
              res.status = ST_NO_NEXT;
            end else begin
              res.new_id  = cur_next;
              cur_next    = spare_start;
              cur_limit   = spare_limit;
              spare_start = '0;
              spare_limit = '0;
            end
          end else begin
            res.new_id = cur_next;
            cur_next   = nxt[ID_W-1:0];
          end
        end
        OP_REFILL: begin
          need  = (spare_start == '0);
          ranks = (total > NR_W'(MAX_RANKS)) ? NR_W'(MAX_RANKS) : total;
          init  = 65'(cursor) + 65'(lower) * 65'(cfg_bs);
          lim_a = init + 65'(cfg_bs);
          adv   = 65'(cursor) + 65'(ranks) * 65'(cfg_bs);
          if ((need && lim_a > ID_LIMIT) || adv > ID_LIMIT) begin
            res.status = ST_OVERFLOW;
          end else begin
            if (need) begin
              spare_start = init[ID_W-1:0];
              spare_limit = lim_a[ID_W-1:0];
            end
            cursor = adv[ID_W-1:0];
          end
        end
        default: ;
      endcase
    end
    res.next_batch_empty = (spare_start == '0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_en      = 1'b1;
      cfg_bs      = BS_W'(1);
      cfg_rank    = '0;
      cfg_nr      = NR_W'(1);
      cursor      = '0;
      cur_next    = '0;
      cur_limit   = '0;
      spare_start = '0;
      spare_limit = '0;
      expected_rsp_q.delete();
      fail_cnt    = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENABLED:    cfg_en   = cfg_data[0];
          CFG_BLOCK_LEN:  cfg_bs   = cfg_data[BS_W-1:0];
          CFG_RANK_INDEX: cfg_rank = cfg_data[RANK_W-1:0];
          CFG_NUM_RANKS:  cfg_nr   = cfg_data[NR_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        allocate(req.opcode, req.id_value, req.lower_requests, req.total_requests,
                 predicted);
        expected_rsp_q.push_back(predicted);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response: new_id %0d status %0d next_batch_empty %0d",
                 rsp.new_id, rsp.status, rsp.next_batch_empty);
          fail_cnt++;
        end else begin
          oldest = expected_rsp_q.pop_front();
          if (rsp.new_id !== oldest.new_id) begin
            $error("new_id: expected %0d, actual %0d", oldest.new_id, rsp.new_id);
            fail_cnt++;
          end
          if (rsp.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, rsp.status);
            fail_cnt++;
          end
          if (rsp.next_batch_empty !== oldest.next_batch_empty) begin
            $error("next_batch_empty: expected %0d, actual %0d",
                   oldest.next_batch_empty, rsp.next_batch_empty);
            fail_cnt++;
          end
        end
      end
    end
    errors  <= fail_cnt;
    pending <= expected_rsp_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top-level testbench: clock, reset, request and response traffic, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bua_pkg::*;

  localparam int ITEM_TARGET = 830;
  localparam int RX_HOLD     = 150;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;

  int hold_token = 0;
  int items_sent = 0;
  int tx_mode    = 0;
  int tx_left    = 0;
  bit burst      = 1'b0;

  bua_in_if  req_if ();
  bua_out_if rsp_if ();

  batched_unique_id_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  alloc_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_id();
    case ($urandom_range(0, 9))
      6:       return rand64();
      7:       return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
      8:       return {1'b1, 31'($urandom), 32'($urandom)};
      9:       return 64'($urandom);
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic offer_request(input logic [OP_W-1:0] op, input logic [63:0] idv,
                               input logic [RANK_W-1:0] lower,
                               input logic [NR_W-1:0] total);
    int gap;
    if (tx_left == 0) begin
      tx_mode = $urandom_range(0, 2);
      tx_left = $urandom_range(10, 60);
    end
    tx_left--;
    gap = burst ? 0 : draw_gap(tx_mode);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.opcode         <= op;
    req_if.id_value       <= idv;
    req_if.lower_requests <= lower;
    req_if.total_requests <= total;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    offer_request(op, rand64(), RANK_W'($urandom), NR_W'($urandom));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic en, input logic [BS_W-1:0] bs,
                           input logic [RANK_W-1:0] rank, input logic [NR_W-1:0] nr);
    logic [CFG_W-1:0] junk;
    drain();
    junk = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom) : '0;
    write_reg(CFG_ENABLED, {junk[CFG_W-1:1], en});
    write_reg(CFG_BLOCK_LEN, bs);
    write_reg(CFG_RANK_INDEX, {junk[CFG_W-1:RANK_W], rank});
    write_reg(CFG_NUM_RANKS, {junk[CFG_W-1:NR_W], nr});
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int rx_wait;
    int rx_mode;
    int rx_left;
    int hold_seen;
    rx_wait   = 0;
    rx_mode   = 0;
    rx_left   = 0;
    hold_seen = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (hold_token != hold_seen) begin
          hold_seen = hold_token;
          rx_wait   = RX_HOLD;
        end else if (rsp_if.valid && rsp_if.ready) begin
          if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(10, 60);
          end
          rx_left--;
          rx_wait = draw_gap(rx_mode);
        end else if (rx_wait > 0) begin
          rx_wait--;
        end
        rsp_if.ready <= (rx_wait == 0);
      end
    end
  end

  initial begin
    logic              en;
    logic [BS_W-1:0]   bs;
    logic [RANK_W-1:0] rank;
    logic [NR_W-1:0]   nr;
    logic [RANK_W-1:0] lower;
    logic [NR_W-1:0]   total;
    logic [OP_W-1:0]   op;
    int                r;
    bit                pressure_done;
    pressure_done = 1'b0;
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    req_if.valid          = 1'b0;
    req_if.opcode         = '0;
    req_if.id_value       = '0;
    req_if.lower_requests = '0;
    req_if.total_requests = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_op(OP_GET_ID);
    send_op(3'd5);
    send_op(3'd7);
    offer_request(OP_SCAN_ID, 64'h8000_0000_0000_0000, '0, '0);
    offer_request(OP_SCAN_ID, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_op(OP_FINISH_INIT);
    offer_request(OP_REFILL, rand64(), '0, NR_W'(1));
    send_op(OP_BEGIN_INIT);
    offer_request(OP_SCAN_ID, 64'd100, '0, '0);
    send_op(OP_FINISH_INIT);
    send_op(OP_GET_ID);
    send_op(OP_GET_ID);
    offer_request(OP_REFILL, rand64(), '0, 11'h7FF);
    offer_request(OP_REFILL, rand64(), 10'h3FF, NR_W'(MAX_RANKS));
    send_op(OP_GET_ID);

    configure(1'b0, BS_W'(3), '0, NR_W'(2));
    send_op(OP_BEGIN_INIT);
    offer_request(OP_SCAN_ID, 64'd500, '0, '0);
    send_op(OP_FINISH_INIT);
    send_op(OP_GET_ID);
    send_op(OP_REFILL);
    send_op(3'd6);

    configure(1'b1, 32'hFFFF_FFFF, 10'h3FF, 11'h7FF);
    send_op(OP_BEGIN_INIT);
    send_op(OP_FINISH_INIT);
    send_op(OP_GET_ID);

    configure(1'b1, '0, RANK_W'(5), '0);
    send_op(OP_BEGIN_INIT);
    send_op(OP_FINISH_INIT);
    send_op(OP_GET_ID);

    while (items_sent < ITEM_TARGET) begin
      en = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
        0:       bs = '0;
        1:       bs = 32'hFFFF_FFFF;
        2:       bs = $urandom;
        default: bs = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       rank = 10'h3FF;
        1:       rank = RANK_W'($urandom);
        default: rank = RANK_W'($urandom_range(0, 7));
      endcase
      case ($urandom_range(0, 9))
        0:       nr = '0;
        1:       nr = 11'h7FF;
        2:       nr = NR_W'(MAX_RANKS);
        3:       nr = NR_W'($urandom);
        default: nr = NR_W'($urandom_range(1, 12));
      endcase
      configure(en, bs, rank, nr);

      if (!pressure_done && en) begin
        hold_token <= hold_token + 1;
        burst = 1'b1;
      end

      if ($urandom_range(0, 9) != 0) begin
        send_op(OP_BEGIN_INIT);
        repeat ($urandom_range(0, 4))
          offer_request(OP_SCAN_ID, pick_id(), RANK_W'($urandom), NR_W'($urandom));
        send_op(OP_FINISH_INIT);
      end

      repeat ($urandom_range(15, 45)) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_op(OP_GET_ID);
        end else if (r < 78) begin
          if ($urandom_range(0, 9) < 7) begin
            lower = RANK_W'($urandom_range(0, 3));
            total = NR_W'(lower) + NR_W'($urandom_range(0, 3));
          end else begin
            lower = RANK_W'($urandom);
            total = NR_W'($urandom);
          end
          offer_request(OP_REFILL, rand64(), lower, total);
        end else if (r < 86) begin
          offer_request(OP_SCAN_ID, pick_id(), RANK_W'($urandom), NR_W'($urandom));
        end else if (r < 90) begin
          send_op(OP_FINISH_INIT);
        end else if (r < 93) begin
          send_op(OP_BEGIN_INIT);
        end else begin
          op = OP_W'($urandom_range(0, 7));
          send_op(op);
        end
      end

      if (burst) begin
        burst = 1'b0;
        pressure_done = 1'b1;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
